// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define MRPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MRPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MRPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/mrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpc_pkg
// Shared widths, command codes and configuration type of the relay controller.
// ----------------------------------------------------------------------------
package mrpc_pkg;

    localparam int MRPC_MAX_CHANNELS = 8;

    localparam int TICK_W    = 32;
    localparam int DUR_W     = 31;
    localparam int MODE_W    = 3;
    localparam int CHAN_W    = 3;
    localparam int PIN_W     = 8;
    localparam int CNT_REG_W = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFF     = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_START  = 3'd0,
        MODE_TICK   = 3'd1,
        MODE_ON     = 3'd2,
        MODE_OFF    = 3'd3,
        MODE_TOGGLE = 3'd4,
        MODE_PULSE  = 3'd5,
        MODE_QUERY  = 3'd6
    } mrpc_mode_t;

    typedef struct packed {
        logic [CNT_REG_W-1:0] channel_count;
        logic                 active_low;
        logic                 start_off;
    } mrpc_cfg_t;

endpackage

// ===== hw/rtl/mrpc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mrpc_cmd_if
// Command channel: valid/ready handshake with mode, channel and duration.
// ----------------------------------------------------------------------------
interface mrpc_cmd_if
    import mrpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] channel;
    logic [DUR_W-1:0]  duration_ms;

    modport source (output valid, output mode, output channel, output duration_ms,
                    input ready);
    modport sink   (input valid, input mode, input channel, input duration_ms,
                    output ready);
endinterface

// ===== hw/rtl/mrpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mrpc_rsp_if
// Response channel: valid/ready handshake with status and pin levels.
// ----------------------------------------------------------------------------
interface mrpc_rsp_if
    import mrpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             channel_on;
    logic [PIN_W-1:0] pin_levels;

    modport source (output valid, output accepted, output channel_on, output pin_levels,
                    input ready);
    modport sink   (input valid, input accepted, input channel_on, input pin_levels,
                    output ready);
endinterface

// ===== hw/rtl/multi_channel_relay_pulse_ctrl_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_relay_pulse_ctrl_core
// Relay driver with one-shot pulses: per-channel on state, pulse end times
// in a memory, and a millisecond tick counter.
//
//   port     | role   | content
//   ---------+--------+------------------------------------------
//   cmd      | sink   | mode, channel, duration_ms
//   rsp      | source | accepted, channel_on, pin_levels
//   cfg_*    | write  | channel_count, active_low, start_off
//
// Start, on, off, toggle, pulse and query: result on the next edge. Tick: the
// sweep visits each effective channel (none with a count of zero), then the
// result is registered once the last expiry check is done and rsp is free;
// the sweep reads one pulse end per cycle through the single read port of the
// end time memory. One transaction is in work at a time; cmd is held off while
// rsp stalls. Reset clears all flags and the counter; the end time memory needs
// no clearing since an entry is only used while its pulse is armed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_relay_pulse_ctrl_core
    import mrpc_pkg::*;
#(
    parameter int MAX_CHANNELS = MRPC_MAX_CHANNELS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    mrpc_cmd_if.sink             cmd,
    mrpc_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CNT_REG_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CNT_REG_W-1:0] channel_count_reg;
    logic                 active_low_reg;
    logic                 start_off_reg;
    mrpc_cfg_t            cfg;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [TICK_W-1:0]    mem_wr_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [TICK_W-1:0]    mem_rd_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CNT_REG_W'(8);
            active_low_reg    <= 1'b1;
            start_off_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata;
                CFG_ACTIVE_LOW:    active_low_reg    <= cfg_wdata[0];
                CFG_START_OFF:     start_off_reg     <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    assign cfg.channel_count = channel_count_reg;
    assign cfg.active_low    = active_low_reg;
    assign cfg.start_off     = start_off_reg;

    // Pulse end time store
    mrpc_end_mem #(
        .DEPTH  (MAX_CHANNELS),
        .ADDR_W (IDX_W),
        .DATA_W (TICK_W)
    ) u_end_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Command sequencer
    mrpc_engine #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // A command is taken only when the response slot is free
    `MRPC_ASSERT_IMP(a_cmd_needs_slot, clk, rst_n, cmd.valid && cmd.ready,
                     !rsp.valid || rsp.ready, "command taken while response stalled")
    // A query answers on the next edge
    `MRPC_ASSERT_NXT(a_query_latency, clk, rst_n,
                     cmd.valid && cmd.ready && (cmd.mode == MODE_QUERY), rsp.valid,
                     "query response missing")
    // End times are written only by an accepted command
    `MRPC_ASSERT_IMP(a_wr_on_accept, clk, rst_n, mem_wr_en, cmd.valid && cmd.ready,
                     "end time write without command")
    // No write while the sweep reads
    `MRPC_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, mem_wr_en, !mem_rd_en,
                     "end time write during sweep")

endmodule

// ===== hw/rtl/mrpc_end_mem.sv =====
// ----------------------------------------------------------------------------
// mrpc_end_mem
// Pulse end time store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrpc_end_mem
    import mrpc_pkg::*;
#(
    parameter int DEPTH  = MRPC_MAX_CHANNELS,
    parameter int ADDR_W = 3,
    parameter int DATA_W = TICK_W
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/mrpc_engine.sv =====
// ----------------------------------------------------------------------------
// mrpc_engine
// Command sequencer: relay and pulse flags, tick counter, expiry sweep over
// the pulse end store, and the response register.
// ----------------------------------------------------------------------------
module mrpc_engine
    import mrpc_pkg::*;
#(
    parameter  int MAX_CHANNELS = MRPC_MAX_CHANNELS,
    localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  mrpc_cfg_t         cfg,
    mrpc_cmd_if.sink          cmd,
    mrpc_rsp_if.source        rsp,
    output logic              mem_wr_en,
    output logic [IDX_W-1:0]  mem_wr_addr,
    output logic [TICK_W-1:0] mem_wr_data,
    output logic              mem_rd_en,
    output logic [IDX_W-1:0]  mem_rd_addr,
    input  logic [TICK_W-1:0] mem_rd_data
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
    localparam int PAD_W = (MAX_CHANNELS > PIN_W) ? MAX_CHANNELS : PIN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [TICK_W-1:0]       now_reg;
    logic                    started_reg;
    logic [MAX_CHANNELS-1:0] relay_on_reg;
    logic [MAX_CHANNELS-1:0] active_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    chk_vld_reg;
    logic [IDX_W-1:0]        chk_idx_reg;
    logic [IDX_W-1:0]        tick_ch_reg;
    logic                    tick_ok_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_accepted_reg;
    logic                    rsp_channel_on_reg;
    logic [PIN_W-1:0]        rsp_pins_reg;

    logic [CMP_W-1:0]        eff_cnt;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    slot_free;
    logic                    cmd_fire;
    logic                    cmd_ok;
    logic [IDX_W-1:0]        ch_idx;
    mrpc_mode_t              mode;
    logic [MAX_CHANNELS-1:0] relay_next;
    logic [MAX_CHANNELS-1:0] active_next;
    logic                    started_next;
    logic                    acc_next;
    logic                    go_sweep;
    logic                    arm_pulse;
    logic [TICK_W-1:0]       diff;
    logic                    expire;
    logic                    sweep_last;
    logic                    finish_done;
    logic                    rsp_load;

    // Map logical on states to pin levels, inactive past the count
    function automatic logic [PIN_W-1:0] pin_map(
        input logic [MAX_CHANNELS-1:0] on_vec,
        input logic [CMP_W-1:0]        cnt,
        input logic                    act_low
    );
        logic [PAD_W-1:0] padded;
        logic [PIN_W-1:0] pins;
        padded = PAD_W'(on_vec);
        for (int i = 0; i < PIN_W; i++)
        begin
            pins[i] = ((CMP_W'(i) < cnt) && padded[i]) ^ act_low;
        end
        return pins;
    endfunction

    // Saturate the channel count at the build maximum
    assign cnt_ext = CMP_W'(cfg.channel_count);
    assign eff_cnt = (cnt_ext > CMP_W'(MAX_CHANNELS)) ? CMP_W'(MAX_CHANNELS) : cnt_ext;

    // Handshake
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && slot_free;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd_ok    = CMP_W'(cmd.channel) < eff_cnt;
    assign ch_idx    = IDX_W'(cmd.channel);
    assign mode      = mrpc_mode_t'(cmd.mode);

    // Decode one command into next flag values
    always_comb
    begin
        relay_next   = relay_on_reg;
        active_next  = active_reg;
        started_next = started_reg;
        acc_next     = 1'b0;
        go_sweep     = 1'b0;
        arm_pulse    = 1'b0;
        unique case (mode)
            MODE_START:
            begin
                if (eff_cnt != '0)
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                    begin
                        relay_next[i] = (CMP_W'(i) < eff_cnt) && !cfg.start_off;
                    end
                    active_next  = '0;
                    started_next = 1'b1;
                    acc_next     = 1'b1;
                end
            end
            MODE_TICK:
            begin
                if (started_reg)
                begin
                    acc_next = 1'b1;
                    go_sweep = 1'b1;
                end
            end
            MODE_ON, MODE_OFF, MODE_TOGGLE:
            begin
                if (cmd_ok)
                begin
                    relay_next[ch_idx]  = (mode == MODE_ON)  ? 1'b1 :
                                          (mode == MODE_OFF) ? 1'b0 : !relay_on_reg[ch_idx];
                    active_next[ch_idx] = 1'b0;
                    acc_next            = 1'b1;
                end
            end
            MODE_PULSE:
            begin
                if (cmd_ok)
                begin
                    relay_next[ch_idx]  = 1'b1;
                    arm_pulse           = (cmd.duration_ms != '0);
                    active_next[ch_idx] = arm_pulse;
                    acc_next            = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                acc_next = cmd_ok;
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    // Arm a pulse end time
    assign mem_wr_en   = cmd_fire && arm_pulse;
    assign mem_wr_addr = ch_idx;
    assign mem_wr_data = now_reg + TICK_W'(cmd.duration_ms);

    // Sweep read, one channel per cycle
    assign mem_rd_en   = (state_reg == ST_SWEEP);
    assign mem_rd_addr = idx_reg;
    assign sweep_last  = (CMP_W'(idx_reg) == (eff_cnt - CMP_W'(1)));

    // Wrap-safe expiry check on the returned end time
    assign diff   = now_reg - mem_rd_data;
    assign expire = chk_vld_reg && active_reg[chk_idx_reg] && !diff[TICK_W-1];

    assign finish_done = (state_reg == ST_FINISH) && !chk_vld_reg && slot_free;

    // A new response enters the slot this cycle
    assign rsp_load = (cmd_fire && !go_sweep) || finish_done;

    // Response port
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.accepted   = rsp_accepted_reg;
    assign rsp.channel_on = rsp_channel_on_reg;
    assign rsp.pin_levels = rsp_pins_reg;

    // State, flags and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            started_reg   <= 1'b0;
            relay_on_reg  <= '0;
            active_reg    <= '0;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            tick_ch_reg   <= '0;
            tick_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop a taken response unless a new one replaces it
            if (rsp_valid_reg && rsp.ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // Track the read in flight
            chk_vld_reg <= (state_reg == ST_SWEEP);
            chk_idx_reg <= idx_reg;

            // Switch off an expired pulse
            if (expire)
            begin
                relay_on_reg[chk_idx_reg] <= 1'b0;
                active_reg[chk_idx_reg]   <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        relay_on_reg <= relay_next;
                        active_reg   <= active_next;
                        started_reg  <= started_next;
                        if (go_sweep)
                        begin
                            now_reg     <= now_reg + TICK_W'(1);
                            idx_reg     <= '0;
                            tick_ch_reg <= ch_idx;
                            tick_ok_reg <= cmd_ok;
                            state_reg   <= (eff_cnt == '0) ? ST_FINISH : ST_SWEEP;
                        end
                        else
                        begin
                            rsp_valid_reg      <= 1'b1;
                            rsp_accepted_reg   <= acc_next;
                            rsp_channel_on_reg <= cmd_ok && relay_next[ch_idx];
                            rsp_pins_reg       <= pin_map(relay_next, eff_cnt,
                                                          cfg.active_low);
                        end
                    end
                end
                ST_SWEEP:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (sweep_last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_done)
                    begin
                        rsp_valid_reg      <= 1'b1;
                        rsp_accepted_reg   <= 1'b1;
                        rsp_channel_on_reg <= tick_ok_reg && relay_on_reg[tick_ch_reg];
                        rsp_pins_reg       <= pin_map(relay_on_reg, eff_cnt,
                                                      cfg.active_low);
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
